### hdl/surface_voxel_extractor_top_assert.svh
// ----------------------------------------------------------------------------
// surface voxel extractor assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SURFACE_VOXEL_EXTRACTOR_TOP_ASSERT_SVH
`define SURFACE_VOXEL_EXTRACTOR_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SVE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sve_pkg.sv
// ----------------------------------------------------------------------------
// sve_pkg
// shared constants, types and helpers of the surface voxel extractor
// ----------------------------------------------------------------------------
package sve_pkg;

    // default volume limits
    localparam int SVE_MAX_DEPTH_DEF  = 256;
    localparam int SVE_MAX_HEIGHT_DEF = 128;
    localparam int SVE_MAX_WIDTH_DEF  = 128;

    // configuration register reset values
    localparam logic [8:0] VOL_DEPTH_RST  = 9'd256;
    localparam logic [7:0] VOL_HEIGHT_RST = 8'd128;
    localparam logic [7:0] VOL_WIDTH_RST  = 8'd128;

    // port widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    // result record field positions in m_tdata
    localparam int OUT_Z_LSB     = 0;
    localparam int OUT_Y_LSB     = 8;
    localparam int OUT_X_LSB     = 15;
    localparam int OUT_COUNT_LSB = 22;
    localparam int OUT_PAD_LSB   = 45;
    localparam int COUNT_W       = 23;

    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    // configuration register index
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VOL_DEPTH  = 2'd0,
        CFG_VOL_HEIGHT = 2'd1,
        CFG_VOL_WIDTH  = 2'd2
    } cfg_reg_t;

    // occupancy words read for one voxel, bit i is plane parity i
    typedef struct packed {
        logic [1:0] ctr;   // same row, same column
        logic [1:0] xp;    // next column
        logic [1:0] ym;    // previous row
        logic [1:0] yp;    // next row
    } nbr_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        int unsigned r;
        if (v == 0) begin
            r = 1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hdl/sve_occ_store.sv
// ----------------------------------------------------------------------------
// sve_occ_store
// two-plane occupancy store, duplicated so four words read per request
// ----------------------------------------------------------------------------
module sve_occ_store import sve_pkg::*; #(
    parameter int AW = 14
) (
    input  logic          aclk,
    input  logic          en,        // one request enters
    input  logic          wr_bit,    // occupancy of the arriving voxel
    input  logic          wr_par,    // plane parity written
    input  logic [AW-1:0] addr_c,
    input  logic [AW-1:0] addr_xp,
    input  logic [AW-1:0] addr_ym,
    input  logic [AW-1:0] addr_yp,
    output nbr_t          rd
);

    localparam int DEPTH = 1 << AW;

    logic [1:0] mem_a [0:DEPTH-1];
    logic [1:0] mem_b [0:DEPTH-1];
    nbr_t       rd_reg;

    // read-first: the centre word still shows the plane two back
    always_ff @(posedge aclk) begin
        if (en) begin
            mem_a[addr_c][wr_par] <= wr_bit;
            rd_reg.ctr            <= mem_a[addr_c];
            rd_reg.xp             <= mem_a[addr_xp];
            mem_b[addr_c][wr_par] <= wr_bit;
            rd_reg.ym             <= mem_b[addr_ym];
            rd_reg.yp             <= mem_b[addr_yp];
        end
    end

    assign rd = rd_reg;

endmodule

### hdl/surface_voxel_extractor_top.sv
// ----------------------------------------------------------------------------
// surface_voxel_extractor_top
// finds 6-connected surface voxels of a raster-ordered volume
// ----------------------------------------------------------------------------
//  channel | ports                                  | moves
//  s_      | s_tvalid s_tready s_tdata[7:0]         | voxel_value
//  m_      | m_tvalid m_tready m_tdata[47:0] m_tlast | coordinates or count
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | register write
//
//  one voxel per cycle while s_tready is high; the store is read when a voxel
//  is taken; the decision uses the registered read words in the next cycle
//  a voxel that yields both a surface record and the end record holds the
//  input until both are taken, as the output register takes one record a cycle
//  aresetn is synchronous; the occupancy store needs no clearing pass
//  a stalled m_ side backs up through one decision stage and the output register
module surface_voxel_extractor_top import sve_pkg::*; #(
    parameter int MAX_DEPTH  = SVE_MAX_DEPTH_DEF,
    parameter int MAX_HEIGHT = SVE_MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = SVE_MAX_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // [7:0] voxel_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] surface_z, [14:8] surface_y, [21:15] surface_x,
    // [44:22] surface_count, [47:45] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,    // end_of_scan
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ZW = $clog2(MAX_DEPTH + 1);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW = YW + XW;

    // configuration
    logic [8:0] vol_depth_reg;
    logic [7:0] vol_height_reg;
    logic [7:0] vol_width_reg;
    logic       cfg_wr;

    logic [ZW-1:0] d_eff;
    logic [YW:0]   h_eff;
    logic [XW:0]   w_eff;

    // scan position of the arriving voxel
    logic [ZW-1:0] z_reg, z_next;
    logic [YW-1:0] y_reg, y_next;
    logic [XW-1:0] x_reg, x_next;
    logic          x_last, y_last, z_pad, scan_last;

    // decision stage
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_done_reg, s1_done_next;
    logic [7:0]    s1_zc_reg;
    logic [6:0]    s1_y_reg;
    logic [6:0]    s1_x_reg;
    logic          s1_has_prev_reg, s1_first_reg, s1_pad_reg, s1_occ_reg;
    logic          s1_ylo_reg, s1_yhi_reg, s1_xlo_reg, s1_xhi_reg;
    logic          s1_last_reg, s1_pc_reg;
    logic          prev_ctr_reg;
    nbr_t          nbr;

    logic          ctr, z2, xp1, ym1, yp1, surf;
    logic          need_surf, need_end, out_free, emit, retire, accept, occ;

    // counts and output register
    logic [COUNT_W-1:0]     found_reg, found_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    // effective dimensions
    assign d_eff = ZW'(clamp_dim(32'(vol_depth_reg), MAX_DEPTH));
    assign h_eff = (YW + 1)'(clamp_dim(32'(vol_height_reg), MAX_HEIGHT));
    assign w_eff = (XW + 1)'(clamp_dim(32'(vol_width_reg), MAX_WIDTH));

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_depth_reg  <= VOL_DEPTH_RST;
            vol_height_reg <= VOL_HEIGHT_RST;
            vol_width_reg  <= VOL_WIDTH_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_VOL_DEPTH:  vol_depth_reg  <= cfg_data;
                CFG_VOL_HEIGHT: vol_height_reg <= cfg_data[7:0];
                CFG_VOL_WIDTH:  vol_width_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // position flags of the arriving voxel
    assign x_last    = ({1'b0, x_reg} == (w_eff - 1'b1));
    assign y_last    = ({1'b0, y_reg} == (h_eff - 1'b1));
    assign z_pad     = (z_reg >= d_eff);
    assign scan_last = z_pad && y_last && x_last;
    assign occ       = (s_tdata != '0);

    // occupancy store: read centre and neighbours, write this voxel
    sve_occ_store #(
        .AW (AW)
    ) u_store (
        .aclk    (aclk),
        .en      (accept),
        .wr_bit  (occ && !z_pad),
        .wr_par  (z_reg[0]),
        .addr_c  ({y_reg, x_reg}),
        .addr_xp ({y_reg, XW'(x_reg + 1'b1)}),
        .addr_ym ({YW'(y_reg - 1'b1), x_reg}),
        .addr_yp ({YW'(y_reg + 1'b1), x_reg}),
        .rd      (nbr)
    );

    // surface test of voxel (z-1, y, x)
    assign ctr  = nbr.ctr[s1_pc_reg];
    assign z2   = nbr.ctr[~s1_pc_reg];
    assign xp1  = nbr.xp[s1_pc_reg];
    assign ym1  = nbr.ym[s1_pc_reg];
    assign yp1  = nbr.yp[s1_pc_reg];
    assign surf = s1_has_prev_reg && ctr &&
                  (s1_first_reg || !z2 || s1_pad_reg || !s1_occ_reg ||
                   s1_ylo_reg || !ym1 || s1_yhi_reg || !yp1 ||
                   s1_xlo_reg || !prev_ctr_reg || s1_xhi_reg || !xp1);

    // record hand-off to the output register
    assign need_surf = s1_valid_reg && surf && !s1_done_reg;
    assign need_end  = s1_valid_reg && s1_last_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = (need_surf || need_end) && out_free;
    assign retire    = s1_valid_reg &&
                       (!(need_surf || need_end) || (out_free && !(need_surf && need_end)));
    assign s_tready  = !s1_valid_reg || retire;
    assign accept    = s_tvalid && s_tready;

    // scan counters
    always_comb begin
        z_next = z_reg;
        y_next = y_reg;
        x_next = x_reg;
        if (cfg_wr) begin
            z_next = '0;
            y_next = '0;
            x_next = '0;
        end else if (accept) begin
            if (scan_last) begin
                z_next = '0;
                y_next = '0;
                x_next = '0;
            end else if (x_last) begin
                x_next = '0;
                if (y_last) begin
                    y_next = '0;
                    z_next = z_reg + 1'b1;
                end else begin
                    y_next = y_reg + 1'b1;
                end
            end else begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    // decision stage occupancy
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_done_next  = s1_done_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
            s1_done_next  = 1'b0;
        end else if (retire) begin
            s1_valid_next = 1'b0;
        end else if (emit && need_surf) begin
            s1_done_next = 1'b1;
        end
    end

    // output record and running count
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        found_next     = found_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            if (need_surf) begin
                out_data_next = {3'b000, {COUNT_W{1'b0}}, s1_x_reg, s1_y_reg, s1_zc_reg};
                out_last_next = 1'b0;
                if (found_reg != COUNT_SAT) begin
                    found_next = found_reg + 1'b1;
                end
            end else begin
                out_data_next = {3'b000, found_reg, 7'd0, 7'd0, 8'd0};
                out_last_next = 1'b1;
                found_next    = '0;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cfg_wr) begin
            found_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_reg         <= '0;
            y_reg         <= '0;
            x_reg         <= '0;
            found_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s1_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            z_reg         <= z_next;
            y_reg         <= y_next;
            x_reg         <= x_next;
            found_reg     <= found_next;
            s1_valid_reg  <= s1_valid_next;
            s1_done_reg   <= s1_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // decision stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_zc_reg       <= 8'(z_reg - 1'b1);
            s1_y_reg        <= 7'(y_reg);
            s1_x_reg        <= 7'(x_reg);
            s1_has_prev_reg <= (z_reg != '0);
            s1_first_reg    <= (z_reg == ZW'(1));
            s1_pad_reg      <= z_pad;
            s1_occ_reg      <= occ;
            s1_ylo_reg      <= (y_reg == '0);
            s1_yhi_reg      <= y_last;
            s1_xlo_reg      <= (x_reg == '0);
            s1_xhi_reg      <= x_last;
            s1_last_reg     <= scan_last;
            s1_pc_reg       <= ~z_reg[0];
            // the voxel before in the row becomes the left neighbour
            prev_ctr_reg    <= ctr;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hdl/sve_checker.sv
// ----------------------------------------------------------------------------
// sve_checker
// port-level checks of the surface voxel extractor result channel
// ----------------------------------------------------------------------------
`include "surface_voxel_extractor_top_assert.svh"

module sve_checker import sve_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // a stalled record holds
    `SVE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result record changed while stalled")

    // the end record carries no coordinates
    `SVE_ASSERT_SAME(a_end_no_coord, aclk, aresetn, m_tvalid && m_tlast, m_tdata[OUT_COUNT_LSB-1:0] == '0, "end record carries coordinates")

    // a surface record carries no count
    `SVE_ASSERT_SAME(a_surf_no_count, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[OUT_PAD_LSB-1:OUT_COUNT_LSB] == '0, "surface record carries a count")

    // filler bits above the count stay zero
    `SVE_ASSERT_SAME(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[OUT_TDATA_W-1:OUT_PAD_LSB] == '0, "filler bits set in a result record")

endmodule

bind surface_voxel_extractor_top sve_checker u_sve_checker (.*);
